FILE: hw/rtl/bdio_pkg.sv
// ----------------------------------------------------------------------------
// bdio_pkg
// Shared types, constants and helpers for the byte-direction digital I/O port.
// ----------------------------------------------------------------------------
`default_nettype none

package bdio_pkg;

	// card slots the present mask covers
	localparam int unsigned SLOTS      = 4;
	localparam int unsigned SLOT_SEL_W = 2;
	localparam int unsigned LANES      = 4;

	// fixed control bits: both test-mode bits and the LED-off bit
	localparam logic [7:0] CTRL_FIXED = 8'hE0;

	// configuration register indexes
	localparam logic CFG_POLARITY = 1'b0;
	localparam logic CFG_PRESENT  = 1'b1;

	typedef enum logic [2:0] {
		REQ_SET_IN   = 3'd0,
		REQ_SET_OUT  = 3'd1,
		REQ_RD_IN    = 3'd2,
		REQ_RD_OUT   = 3'd3,
		REQ_WR_OUT   = 3'd4,
		REQ_SCAN     = 3'd5
	} req_t;

	// per-card state
	typedef struct packed {
		logic [LANES-1:0] in_flags;
		logic [LANES-1:0] out_flags;
		logic [31:0]      last_scan;
		logic             first_scan;
	} card_state_t;

	// state write from the request unit
	typedef struct packed {
		logic        we;
		card_state_t data;
	} card_upd_t;

	// one result item
	typedef struct packed {
		logic        status_error;
		logic [31:0] read_data;
		logic [31:0] data_write_word;
		logic        data_write_strobe;
		logic [7:0]  control_word;
		logic        control_strobe;
		logic        change_detected;
	} result_t;

	// expand byte flags into a bit mask
	function automatic logic [31:0] lanes_to_mask(input logic [LANES-1:0] flags);
		logic [31:0] m;
		m = '0;
		for (int j = 0; j < LANES; j++) begin
			if (flags[j]) m[j*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction

	// bytes touched by a mask
	function automatic logic [LANES-1:0] mask_to_lanes(input logic [31:0] mask);
		logic [LANES-1:0] f;
		for (int j = 0; j < LANES; j++) begin
			f[j] = |mask[j*8 +: 8];
		end
		return f;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bdio_card_regs.sv
// ----------------------------------------------------------------------------
// bdio_card_regs
// Per-card direction flags, last scanned inputs and first-scan flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bdio_card_regs
	import bdio_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 4,
	parameter int unsigned IDX_W     = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic             commit,
	input  wire card_upd_t        upd,
	output card_state_t           cur
);

	card_state_t cards_q [NUM_SLOTS];

	// read the addressed card
	assign cur = cards_q[idx];

	// update on a committed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cards_q[i].in_flags   <= '0;
				cards_q[i].out_flags  <= '0;
				cards_q[i].last_scan  <= '0;
				cards_q[i].first_scan <= 1'b1;
			end
		end else if (commit && upd.we) begin
			cards_q[idx] <= upd.data;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bdio_req_unit.sv
// ----------------------------------------------------------------------------
// bdio_req_unit
// Decodes one request against the addressed card and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module bdio_req_unit
	import bdio_pkg::*;
(
	input  wire logic [2:0]  req_type,
	input  wire logic        usable,
	input  wire logic [31:0] bit_mask,
	input  wire logic [31:0] write_value,
	input  wire logic [31:0] port_readback,
	input  wire logic [31:0] corr,
	input  wire card_state_t cur,
	output result_t          res,
	output card_upd_t        upd
);

	logic [31:0]      inm;
	logic [31:0]      outm;
	logic [LANES-1:0] touched;
	logic [31:0]      now_in;
	card_state_t      nxt;

	assign inm     = lanes_to_mask(cur.in_flags);
	assign outm    = lanes_to_mask(cur.out_flags);
	assign touched = mask_to_lanes(bit_mask);
	assign now_in  = port_readback & inm;

	always_comb begin
		res = '0;
		nxt = cur;
		if (!usable) begin
			res.status_error = 1'b1;
		end else begin
			case (req_t'(req_type))
				REQ_SET_IN: begin
					if ((bit_mask & outm) != '0) res.status_error = 1'b1;
					else nxt.in_flags = cur.in_flags | touched;
				end
				REQ_SET_OUT: begin
					if ((bit_mask & inm) != '0) res.status_error = 1'b1;
					else nxt.out_flags = cur.out_flags | touched;
				end
				REQ_RD_IN: begin
					res.read_data = port_readback & inm & bit_mask;
				end
				REQ_RD_OUT: begin
					res.read_data = ~((port_readback & outm) ^ corr) & bit_mask;
				end
				REQ_WR_OUT: begin
					res.data_write_word = (((~port_readback & ~bit_mask)
						| (write_value & bit_mask)) ^ corr) & outm;
					res.data_write_strobe = 1'b1;
				end
				REQ_SCAN: begin
					if (now_in != cur.last_scan || cur.first_scan) begin
						res.change_detected = 1'b1;
						nxt.last_scan       = now_in;
						nxt.first_scan      = 1'b0;
					end
				end
				default: begin
					res.status_error = 1'b1;
				end
			endcase
			res.control_word   = CTRL_FIXED | {4'b0, nxt.out_flags};
			res.control_strobe = (nxt.out_flags != cur.out_flags);
		end
	end

	assign upd.we   = usable;
	assign upd.data = nxt;

endmodule

`default_nettype wire

FILE: hw/rtl/byte_direction_digital_io_port_core.sv
// ----------------------------------------------------------------------------
// byte_direction_digital_io_port_core
// 32-bit digital I/O port over several cards, direction claimed per byte.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   cfg     | cfg_we             | cfg_index, cfg_wdata
//   in      | in_valid/in_ready  | req_type, card_index, bit_mask,
//           |                    | write_value, port_readback
//   out     | out_valid/out_ready| status_error, read_data, data_write_word,
//           |                    | data_write_strobe, control_word,
//           |                    | control_strobe, change_detected
//
// One item per cycle while out_ready is high; items pass an input register, then a result register.
// Card state is read and written in the cycle an item moves to the result
// register, so the next item always sees it updated.
// Reset clears all card state and sets each first-scan flag; no sweep.
// With out_ready low the result holds and one more item waits in stage 1.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_direction_digital_io_port_core
	import bdio_pkg::*;
#(
	parameter int unsigned NUM_CARDS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [2:0]  card_index,
	input  wire logic [31:0] bit_mask,
	input  wire logic [31:0] write_value,
	input  wire logic [31:0] port_readback,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status_error,
	output logic [31:0]      read_data,
	output logic [31:0]      data_write_word,
	output logic             data_write_strobe,
	output logic [7:0]       control_word,
	output logic             control_strobe,
	output logic             change_detected
);

	localparam int unsigned NUM_SLOTS = (NUM_CARDS < SLOTS) ? NUM_CARDS : SLOTS;
	localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [31:0]      corr_q;
	logic [SLOTS-1:0] present_q;

	logic             valid_s1;
	logic [2:0]       req_type_s1;
	logic [2:0]       card_index_s1;
	logic [31:0]      bit_mask_s1;
	logic [31:0]      write_value_s1;
	logic [31:0]      port_readback_s1;

	logic             out_valid_q;
	result_t          res_q;

	logic             advance;
	logic             usable;
	card_state_t      cur;
	result_t          res;
	card_upd_t        upd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q    <= '0;
			present_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLARITY: corr_q    <= cfg_wdata;
				CFG_PRESENT:  present_q <= cfg_wdata[SLOTS-1:0];
				default:      ;
			endcase
		end
	end

	// pipeline control
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_type_s1      <= req_type;
			card_index_s1    <= card_index;
			bit_mask_s1      <= bit_mask;
			write_value_s1   <= write_value;
			port_readback_s1 <= port_readback;
		end
	end

	// card fitted and in range
	assign usable = ({29'b0, card_index_s1} < NUM_SLOTS)
		&& present_q[card_index_s1[SLOT_SEL_W-1:0]];

	bdio_card_regs #(
		.NUM_SLOTS (NUM_SLOTS),
		.IDX_W     (IDX_W)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (card_index_s1[IDX_W-1:0]),
		.commit (advance),
		.upd    (upd),
		.cur    (cur)
	);

	bdio_req_unit u_req (
		.req_type      (req_type_s1),
		.usable        (usable),
		.bit_mask      (bit_mask_s1),
		.write_value   (write_value_s1),
		.port_readback (port_readback_s1),
		.corr          (corr_q),
		.cur           (cur),
		.res           (res),
		.upd           (upd)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign out_valid         = out_valid_q;
	assign status_error      = res_q.status_error;
	assign read_data         = res_q.read_data;
	assign data_write_word   = res_q.data_write_word;
	assign data_write_strobe = res_q.data_write_strobe;
	assign control_word      = res_q.control_word;
	assign control_strobe    = res_q.control_strobe;
	assign change_detected   = res_q.change_detected;

endmodule

`default_nettype wire
